@@ rtl/wbs_pkg.sv @@
// Shared types, constants and control structs for the weighted bandwidth share unit.
package wbs_pkg;

    parameter int MAX_GROUPS  = 16;
    parameter int RATIO_W     = 10;
    parameter int TOTAL_W     = 32;
    parameter int FIELD_IDX_W = 5;
    parameter int CNT_W       = $clog2(MAX_GROUPS + 1);
    parameter int ADDR_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    parameter int SUM_W       = $clog2(MAX_GROUPS * ((1 << RATIO_W) - 1) + 1);
    parameter int ROOT_W      = 7;

    parameter int BIG_SUM_LIMIT = 90;
    parameter int PERCENT       = 100;
    parameter int ROOT_MIN      = 10;

    parameter int DVS_MAX = MAX_GROUPS * ((1 << RATIO_W) - 1) * PERCENT / BIG_SUM_LIMIT;
    parameter int DVS_W   = (DVS_MAX > PERCENT) ? $clog2(DVS_MAX + 1) : $clog2(PERCENT + 1);
    parameter int PROD_W  = TOTAL_W + RATIO_W;
    parameter int STEP_W  = $clog2(PROD_W + 1);

    typedef enum logic {
        ACT_ADD    = 1'b0,
        ACT_RECALC = 1'b1
    } action_t;

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_ZERO = 2'd2
    } status_t;

    typedef enum logic {
        REG_TOTAL_BW_OUT = 1'b0,
        REG_TOTAL_BW_IN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_DVS   = 2'd0,
        MUL_ROOT  = 2'd1,
        MUL_GROUP = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SUM_START,
        S_SUM_READ,
        S_SUM_ADD,
        S_SHARE,
        S_DVS_MUL,
        S_DVS_DIV,
        S_ROOT_MUL,
        S_LIM_DIV,
        S_EMIT,
        S_GRP_MUL
    } state_t;

    typedef struct packed {
        logic     in_load;
        logic     add_emit;
        logic     sum_clear;
        logic     sum_add;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
        logic     set_root;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_step;
        logic     dvs_save;
        logic     rep_emit;
    } wbs_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic idx_at_n;
        logic sum_big;
        logic div_done;
        logic out_free;
    } wbs_stat_t;

endpackage

@@ rtl/wbs_ctrl.sv @@
// Sequencer for add and recalculate words of the bandwidth share unit.
module wbs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_action,
    output logic              s_ready,
    output wbs_pkg::wbs_cmd_t cmd,
    input  wbs_pkg::wbs_stat_t stat
);
    import wbs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_GROUP;
        cmd.in_load = accept;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (action_t'(s_action) == ACT_RECALC) ? S_SUM_START : S_ADD;
                end
            end
            S_ADD: begin
                if (stat.out_free) begin
                    cmd.add_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SUM_START: begin
                cmd.sum_clear = 1'b1;
                cmd.idx_clear = 1'b1;
                state_next    = stat.n_zero ? S_SHARE : S_SUM_READ;
            end
            S_SUM_READ: begin
                cmd.rd_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SUM_ADD;
            end
            S_SUM_ADD: begin
                cmd.sum_add = 1'b1;
                state_next  = stat.idx_at_n ? S_SHARE : S_SUM_READ;
            end
            S_SHARE: begin
                cmd.set_root  = 1'b1;
                cmd.idx_clear = 1'b1;
                state_next    = stat.sum_big ? S_DVS_MUL : S_ROOT_MUL;
            end
            S_DVS_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DVS;
                state_next  = S_DVS_DIV;
            end
            S_DVS_DIV: begin
                if (stat.div_done) begin
                    cmd.dvs_save = 1'b1;
                    state_next   = S_ROOT_MUL;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_ROOT_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ROOT;
                state_next  = S_LIM_DIV;
            end
            S_LIM_DIV: begin
                if (stat.div_done) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.rep_emit = 1'b1;
                    if (stat.idx_at_n) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.idx_inc = 1'b1;
                        state_next  = S_GRP_MUL;
                    end
                end
            end
            S_GRP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GROUP;
                state_next  = S_LIM_DIV;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/wbs_datapath.sv @@
// Ratio table, sum, two-lane multiply and bit-serial divide, result register.
module wbs_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [wbs_pkg::RATIO_W-1:0] s_share_ratio,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wbs_pkg::TOTAL_W-1:0] cfg_data,
    input  wbs_pkg::wbs_cmd_t           cmd,
    output wbs_pkg::wbs_stat_t          stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [1:0]                  m_status,
    output logic [wbs_pkg::FIELD_IDX_W-1:0] m_group_index,
    output logic [wbs_pkg::FIELD_IDX_W-1:0] m_groups_held,
    output logic [wbs_pkg::TOTAL_W-1:0] m_limit_out,
    output logic [wbs_pkg::TOTAL_W-1:0] m_limit_in,
    output logic                        m_last
);
    import wbs_pkg::*;

    logic [RATIO_W-1:0] ratio_mem [MAX_GROUPS];
    logic [RATIO_W-1:0] rd_data_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [TOTAL_W-1:0] total_out_reg;
    logic [TOTAL_W-1:0] total_in_reg;
    logic [CNT_W-1:0]   group_total_reg;
    logic [ROOT_W-1:0]  root_share_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DVS_W-1:0]   divisor_reg;

    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   rem_o_reg;
    logic [DVS_W-1:0]   rem_i_reg;
    logic [PROD_W-1:0]  dq_o_reg;
    logic [PROD_W-1:0]  dq_i_reg;
    logic [STEP_W-1:0]  step_reg;

    logic               m_valid_reg;
    kind_t              m_kind_reg;
    status_t            m_status_reg;
    logic [FIELD_IDX_W-1:0] m_index_reg;
    logic [FIELD_IDX_W-1:0] m_held_reg;
    logic [TOTAL_W-1:0] m_lim_o_reg;
    logic [TOTAL_W-1:0] m_lim_i_reg;
    logic               m_last_reg;

    logic [TOTAL_W-1:0] mul_a_o;
    logic [TOTAL_W-1:0] mul_a_i;
    logic [RATIO_W-1:0] mul_b;
    logic [DVS_W-1:0]   mul_dvs;
    logic [PROD_W-1:0]  prod_o;
    logic [PROD_W-1:0]  prod_i;
    logic [DVS_W:0]     rsh_o;
    logic [DVS_W:0]     rsh_i;
    logic               ge_o;
    logic               ge_i;
    logic [DVS_W:0]     rdiff_o;
    logic [DVS_W:0]     rdiff_i;
    logic               add_zero;
    logic               add_full;
    logic               add_ok;
    logic [CNT_W-1:0]   gt_inc;

    assign add_zero = (ratio_reg == '0);
    assign add_full = (group_total_reg >= CNT_W'(MAX_GROUPS));
    assign add_ok   = !add_zero && !add_full;
    assign gt_inc   = group_total_reg + CNT_W'(1);

    always_comb begin
        mul_a_o = total_out_reg;
        mul_a_i = total_in_reg;
        mul_b   = rd_data_reg;
        mul_dvs = divisor_reg;
        case (cmd.mul_sel)
            MUL_DVS: begin
                mul_a_o = TOTAL_W'(sum_reg);
                mul_a_i = TOTAL_W'(sum_reg);
                mul_b   = RATIO_W'(PERCENT);
                mul_dvs = DVS_W'(BIG_SUM_LIMIT);
            end
            MUL_ROOT: begin
                mul_b   = RATIO_W'(root_share_reg);
                mul_dvs = DVS_W'(PERCENT);
            end
            default: begin
                mul_b   = rd_data_reg;
                mul_dvs = divisor_reg;
            end
        endcase
    end

    assign prod_o = PROD_W'(mul_a_o) * PROD_W'(mul_b);
    assign prod_i = PROD_W'(mul_a_i) * PROD_W'(mul_b);

    // restoring divide, one quotient bit per lane per cycle
    assign rsh_o   = {rem_o_reg, dq_o_reg[PROD_W-1]};
    assign rsh_i   = {rem_i_reg, dq_i_reg[PROD_W-1]};
    assign ge_o    = (rsh_o >= {1'b0, dvs_reg});
    assign ge_i    = (rsh_i >= {1'b0, dvs_reg});
    assign rdiff_o = ge_o ? (rsh_o - {1'b0, dvs_reg}) : rsh_o;
    assign rdiff_i = ge_i ? (rsh_i - {1'b0, dvs_reg}) : rsh_i;

    assign stat.n_zero   = (group_total_reg == '0);
    assign stat.idx_at_n = (idx_reg == group_total_reg);
    assign stat.sum_big  = (sum_reg > SUM_W'(BIG_SUM_LIMIT));
    assign stat.div_done = (step_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.add_emit && add_ok) begin
            ratio_mem[group_total_reg[ADDR_W-1:0]] <= ratio_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= ratio_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_out_reg   <= '0;
            total_in_reg    <= '0;
            group_total_reg <= '0;
            root_share_reg  <= ROOT_W'(PERCENT);
            idx_reg         <= '0;
            step_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TOTAL_BW_OUT: total_out_reg <= cfg_data;
                    REG_TOTAL_BW_IN:  total_in_reg  <= cfg_data;
                    default:          total_out_reg <= total_out_reg;
                endcase
            end
            if (cmd.add_emit && add_ok) begin
                group_total_reg <= gt_inc;
            end
            if (cmd.set_root) begin
                if (stat.sum_big) begin
                    root_share_reg <= ROOT_W'(ROOT_MIN);
                end else begin
                    root_share_reg <= ROOT_W'(PERCENT - int'(sum_reg));
                end
            end
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.mul_en) begin
                step_reg <= STEP_W'(PROD_W);
            end else if (cmd.div_step) begin
                step_reg <= step_reg - STEP_W'(1);
            end
            if (cmd.add_emit || cmd.rep_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            ratio_reg <= s_share_ratio;
        end
        if (cmd.sum_clear) begin
            sum_reg <= '0;
        end else if (cmd.sum_add) begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.set_root && !stat.sum_big) begin
            divisor_reg <= DVS_W'(PERCENT);
        end else if (cmd.dvs_save) begin
            divisor_reg <= dq_o_reg[DVS_W-1:0];
        end
        if (cmd.mul_en) begin
            dvs_reg   <= mul_dvs;
            rem_o_reg <= '0;
            rem_i_reg <= '0;
            dq_o_reg  <= prod_o;
            dq_i_reg  <= prod_i;
        end else if (cmd.div_step) begin
            rem_o_reg <= rdiff_o[DVS_W-1:0];
            rem_i_reg <= rdiff_i[DVS_W-1:0];
            dq_o_reg  <= {dq_o_reg[PROD_W-2:0], ge_o};
            dq_i_reg  <= {dq_i_reg[PROD_W-2:0], ge_i};
        end
        if (cmd.add_emit) begin
            m_kind_reg   <= KIND_ADD;
            m_status_reg <= add_zero ? STAT_ZERO : (add_full ? STAT_FULL : STAT_OK);
            m_index_reg  <= add_ok ? FIELD_IDX_W'(gt_inc) : '0;
            m_held_reg   <= add_ok ? FIELD_IDX_W'(gt_inc) : FIELD_IDX_W'(group_total_reg);
            m_lim_o_reg  <= '0;
            m_lim_i_reg  <= '0;
            m_last_reg   <= 1'b1;
        end else if (cmd.rep_emit) begin
            m_kind_reg   <= KIND_REPORT;
            m_status_reg <= STAT_OK;
            m_index_reg  <= FIELD_IDX_W'(idx_reg);
            m_held_reg   <= FIELD_IDX_W'(group_total_reg);
            m_lim_o_reg  <= dq_o_reg[TOTAL_W-1:0];
            m_lim_i_reg  <= dq_i_reg[TOTAL_W-1:0];
            m_last_reg   <= stat.idx_at_n;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_status      = m_status_reg;
    assign m_group_index = m_index_reg;
    assign m_groups_held = m_held_reg;
    assign m_limit_out   = m_lim_o_reg;
    assign m_limit_in    = m_lim_i_reg;
    assign m_last        = m_last_reg;

endmodule

@@ rtl/weighted_bandwidth_share_unit.sv @@
// Top level of the weighted bandwidth share unit: sequencer plus datapath.
//
// Input channel s_*: one word per command. s_action 0 adds a group with
// s_share_ratio, s_action 1 recalculates and reports all limits.
// Result channel m_*: an add returns one word (status, new index, count).
// A recalculate returns 1 + groups_held words, root first, m_last on the
// final one. Config channel cfg_*: cfg_index 0 total_bw_out, 1 total_bw_in,
// always ready; write only while the unit is idle.
// An add result is registered once the output register is free.
// A recalculate first sums the table, one read and one add per group,
// then, when the sum exceeds 90, finds the divisor with the serial
// divider; each reported word then takes one multiply, a pass of the
// shared one-bit-per-cycle divider (both directions in parallel lanes)
// and one load of the output register. One command is worked at a time;
// s_ready returns once the last word sits in the output register, so the
// next command is taken while that word still waits.
// Reset clears group count and both totals, sets root share 100; the ratio
// table holds no reset value. When m_ready is low the output register holds
// its word and the sequencer waits before loading the next one.
module weighted_bandwidth_share_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [9:0]  s_share_ratio,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [4:0]  m_group_index,
    output logic [4:0]  m_groups_held,
    output logic [31:0] m_limit_out,
    output logic [31:0] m_limit_in,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import wbs_pkg::*;

    wbs_cmd_t  cmd;
    wbs_stat_t stat;

    assign cfg_ready = 1'b1;

    wbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wbs_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_share_ratio (s_share_ratio),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_status      (m_status),
        .m_group_index (m_group_index),
        .m_groups_held (m_groups_held),
        .m_limit_out   (m_limit_out),
        .m_limit_in    (m_limit_in),
        .m_last        (m_last)
    );

endmodule

@@ rtl/wbs_checker.sv @@
// Port-level checks for the weighted bandwidth share unit, bound to the top level.
module wbs_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [1:0]  m_status,
    input logic [4:0]  m_group_index,
    input logic [31:0] m_limit_out,
    input logic [31:0] m_limit_in,
    input logic        m_last
);
    import wbs_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_limit_out) && $stable(m_limit_in)
                                && $stable(m_group_index) && $stable(m_last))
        else $error("result word changed while stalled");

    a_add_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ADD) |-> m_last && (m_limit_out == '0) && (m_limit_in == '0))
        else $error("add acknowledge not single zero-limit word");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> (m_kind == KIND_ADD) && (m_group_index == '0))
        else $error("rejected add carries group index or wrong kind");

    a_report_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_REPORT) |-> (m_status == STAT_OK))
        else $error("limit report with non-ok status");

endmodule

bind weighted_bandwidth_share_unit wbs_port_checker u_wbs_checker (.*);
